### src/nfba_pkg.sv
// Shared types, constants and helpers for the next-fit block allocator.
// No dependencies; imported by every module of the block.
package nfba_pkg;

    // Pool geometry
    localparam int BLOCKS  = 64;
    localparam int IDX_W   = $clog2(BLOCKS);
    localparam int CNT_W   = $clog2(BLOCKS + 1);
    localparam int BB_W    = 8;
    localparam int OFF_W   = 14;
    localparam int PROD_W  = IDX_W + BB_W + 1;

    // Stream widths
    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 32;
    localparam int OUT_PAD_W   = OUT_TDATA_W - IDX_W - OFF_W - CNT_W;
    localparam int IN_PAD_W    = IN_TDATA_W - IDX_W;

    // Configuration register indexes
    localparam logic CFG_BLOCK_BYTES   = 1'b0;
    localparam logic CFG_BLOCKS_IN_USE = 1'b1;

    // Reset values of the configuration registers
    localparam logic [BB_W-1:0]  BB_RESET  = BB_W'(1);
    localparam logic [CNT_W-1:0] CAP_RESET = CNT_W'(BLOCKS);

    // Request operations
    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_FULL     = 2'd1,
        ST_BAD_FREE = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CALC,
        S_EMIT
    } t_state;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load_req;
        logic commit;
        logic load_out;
    } t_cmd;

    typedef logic [BLOCKS-1:0] t_map;

    typedef struct packed {
        logic             found;
        logic [IDX_W-1:0] idx;
    } t_find;

    // Lowest set bit of a mark vector
    function automatic t_find find_first(input t_map v);
        t_find r;
        r.found = 1'b0;
        r.idx   = '0;
        for (int i = BLOCKS - 1; i >= 0; i--) begin
            if (v[i]) begin
                r.found = 1'b1;
                r.idx   = IDX_W'(i);
            end
        end
        return r;
    endfunction

endpackage

### src/next_fit_block_allocator.sv
// Next-fit pool allocator of equal-size blocks: top level.
// Depends on nfba_pkg, nfba_ctrl and nfba_dp.
//
// One allocate or free request is taken at a time. A request is accepted in
// the idle cycle, its free-mark search (allocate) or mark check (free) and
// the update of marks, scan position and used count happen in the next
// cycle, and the result, with its data offset from a 6 x 9 bit multiply, is
// loaded into the output register in the emit state, as soon as that register
// is free. A new request can be accepted once that result is loaded, while
// it still waits in the output register; the output register stalls the block
// only when a second result is ready before the first has been taken. The
// search over the 64 marks is registered ahead of the offset multiply.
// The marks are cleared by reset at once.
// Configuration writes are always ready and must be made only while no
// request is in flight.
module next_fit_block_allocator
    import nfba_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // Configuration write channel
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic                   i_cfg_index,
    input  logic [BB_W-1:0]        i_cfg_data,
    // Request stream
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // [5:0] block_index, [7:6] zero
    input  logic                   s_axis_tuser,   // [0] operation
    // Result stream
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // [5:0] granted_index,
                                                   // [19:6] data_offset,
                                                   // [26:20] used_count, [31:27] zero
    output logic [1:0]             m_axis_tuser    // [1:0] status
);

    t_cmd cmd;

    assign o_cfg_ready = 1'b1;

    nfba_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_cmd       (cmd)
    );

    nfba_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_cfg_we      (i_cfg_valid),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_operation   (s_axis_tuser),
        .i_block_index (s_axis_tdata[IDX_W-1:0]),
        .o_status      (m_axis_tuser),
        .o_tdata       (m_axis_tdata)
    );

endmodule

### src/nfba_ctrl.sv
// Request sequencer of the next-fit block allocator: accept, search, emit.
// Depends on nfba_pkg; drives the datapath through a t_cmd struct.
module nfba_ctrl
    import nfba_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_cmd o_cmd
);

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;

    // State and output-valid registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // Next state and commands
    always_comb begin
        n_state          = r_state;
        o_cmd            = '0;
        o_in_ready       = 1'b0;
        n_out_valid      = r_out_valid && !i_out_ready;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load_req = 1'b1;
                    n_state        = S_CALC;
                end
            end
            S_CALC: begin
                o_cmd.commit = 1'b1;
                n_state      = S_EMIT;
            end
            S_EMIT: begin
                // hold the result until the output register is free
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.load_out = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_out_valid = r_out_valid;

endmodule

### src/nfba_dp.sv
// Datapath of the next-fit block allocator: marks, counters, search, offset.
// Depends on nfba_pkg; steered by the t_cmd struct from nfba_ctrl.
module nfba_dp
    import nfba_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_cmd                   i_cmd,
    input  logic                   i_cfg_we,
    input  logic                   i_cfg_index,
    input  logic [BB_W-1:0]        i_cfg_data,
    input  logic                   i_operation,
    input  logic [IDX_W-1:0]       i_block_index,
    output logic [1:0]             o_status,
    output logic [OUT_TDATA_W-1:0] o_tdata
);

    logic [BB_W-1:0]        r_block_bytes;
    logic [CNT_W-1:0]       r_blocks_in_use;
    t_map                   r_map;
    logic [IDX_W-1:0]       r_scan;
    logic [CNT_W-1:0]       r_taken;
    logic                   r_op;
    logic [IDX_W-1:0]       r_req;
    t_status                r_res_status;
    logic [IDX_W-1:0]       r_res_idx;
    t_status                r_out_status;
    logic [OUT_TDATA_W-1:0] r_out_tdata;

    logic [CNT_W-1:0] cap;
    logic [IDX_W-1:0] start;
    t_map             v_free;
    t_map             v_hi;
    t_find            f_hi;
    t_find            f_all;
    logic             bad_free;
    logic             full;
    t_status          n_status;
    logic [IDX_W-1:0] n_idx;
    logic [BB_W:0]    stride;
    logic [PROD_W-1:0] prod;
    logic [OFF_W-1:0] offset;

    // Clamp the capacity to 1..BLOCKS
    always_comb begin
        if (r_blocks_in_use == '0) begin
            cap = CNT_W'(1);
        end else if (r_blocks_in_use > CNT_W'(BLOCKS)) begin
            cap = CNT_W'(BLOCKS);
        end else begin
            cap = r_blocks_in_use;
        end
    end

    // Candidate free marks: in range, and at or after the scan start
    always_comb begin
        start = ({1'b0, r_scan} >= cap) ? '0 : r_scan;
        for (int i = 0; i < BLOCKS; i++) begin
            v_free[i] = !r_map[i] && (CNT_W'(i) < cap);
            v_hi[i]   = v_free[i] && (IDX_W'(i) >= start);
        end
        f_hi  = find_first(v_hi);
        f_all = find_first(v_free);
    end

    // Decide the outcome of the held request
    always_comb begin
        full     = r_taken >= cap;
        bad_free = ({1'b0, r_req} >= cap) || !r_map[r_req];
        n_status = ST_OK;
        n_idx    = '0;
        if (r_op == OP_ALLOC) begin
            if (full) begin
                n_status = ST_FULL;
            end else if (f_hi.found) begin
                n_idx = f_hi.idx;
            end else if (f_all.found) begin
                n_idx = f_all.idx;
            end else begin
                n_status = ST_FULL;
            end
        end else begin
            if (bad_free) begin
                n_status = ST_BAD_FREE;
            end else begin
                n_idx = r_req;
            end
        end
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_block_bytes   <= BB_RESET;
            r_blocks_in_use <= CAP_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_BLOCK_BYTES:   r_block_bytes   <= i_cfg_data;
                CFG_BLOCKS_IN_USE: r_blocks_in_use <= i_cfg_data[CNT_W-1:0];
                default:           r_block_bytes   <= r_block_bytes;
            endcase
        end
    end

    // Allocation state: marks, scan position, used count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_map   <= '0;
            r_scan  <= '0;
            r_taken <= '0;
        end else if (i_cmd.commit && n_status == ST_OK) begin
            if (r_op == OP_ALLOC) begin
                r_map[n_idx] <= 1'b1;
                r_scan       <= n_idx;
                r_taken      <= r_taken + CNT_W'(1);
            end else begin
                r_map[n_idx] <= 1'b0;
                if (r_taken != '0) begin
                    r_taken <= r_taken - CNT_W'(1);
                end
            end
        end
    end

    // Request and result holding registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_req) begin
            r_op  <= i_operation;
            r_req <= i_block_index;
        end
        if (i_cmd.commit) begin
            r_res_status <= n_status;
            r_res_idx    <= n_idx;
        end
    end

    // Byte offset of the user data: index * (block_bytes + 1) + 1
    always_comb begin
        stride = {1'b0, r_block_bytes} + (BB_W + 1)'(1);
        prod   = PROD_W'(r_res_idx) * PROD_W'(stride);
        offset = (r_res_status == ST_OK) ? OFF_W'(prod + PROD_W'(1)) : '0;
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out_status <= r_res_status;
            r_out_tdata  <= {{OUT_PAD_W{1'b0}}, r_taken, offset, r_res_idx};
        end
    end

    assign o_status = r_out_status;
    assign o_tdata  = r_out_tdata;

endmodule

### src/nfba_checker.sv
// Port-level checks for the next-fit block allocator, bound to the top level.
// Depends on nfba_pkg and next_fit_block_allocator.
module nfba_checker
    import nfba_pkg::*;
(
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   m_axis_tvalid,
    input logic                   m_axis_tready,
    input logic [OUT_TDATA_W-1:0] m_axis_tdata,
    input logic [1:0]             m_axis_tuser
);

    // A stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("stalled result changed");

    // Only the three defined status codes appear
    a_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tuser == ST_OK || m_axis_tuser == ST_FULL ||
                           m_axis_tuser == ST_BAD_FREE))
        else $error("undefined status");

    // A failed request reports index and offset zero
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser != ST_OK |-> m_axis_tdata[IDX_W+OFF_W-1:0] == '0)
        else $error("failed request carries an index or offset");

    // A granted block has its data past the flag byte
    a_ok_offset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser == ST_OK |-> m_axis_tdata[IDX_W+OFF_W-1:IDX_W] != '0)
        else $error("granted block with zero offset");

    // The used count never exceeds the pool size
    a_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[IDX_W+OFF_W+CNT_W-1:IDX_W+OFF_W] <= CNT_W'(BLOCKS))
        else $error("used count above pool size");

endmodule

bind next_fit_block_allocator nfba_checker u_nfba_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

### tb/tb.sv
// Self-checking bench for next_fit_block_allocator: directed table, then random phases.
// Depends on nfba_pkg and the allocator RTL; expected replies come from a local pool model.
module tb;
    import nfba_pkg::*;

    typedef struct packed {
        t_status          status;
        logic [IDX_W-1:0] blk;
        logic [OFF_W-1:0] offset;
        logic [CNT_W-1:0] used;
    } t_reply;

    typedef enum logic {K_REQ, K_CFG} t_kind;

    // One row of the directed table: a register write or a request
    typedef struct packed {
        t_kind            kind;
        logic             sel;
        logic [BB_W-1:0]  value;
        logic             op;
        logic [IDX_W-1:0] blk;
        logic             pinned;
        t_reply           want;
    } t_step;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_cfg_valid;
    logic                   o_cfg_ready;
    logic                   i_cfg_index;
    logic [BB_W-1:0]        i_cfg_data;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata;
    logic                   s_axis_tuser;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic [1:0]             m_axis_tuser;

    // Local pool model
    logic [BLOCKS-1:0] pool_marks = '0;
    logic [IDX_W-1:0]  scan_at    = '0;
    logic [CNT_W-1:0]  taken      = '0;
    logic [BB_W-1:0]   cfg_bb     = BB_RESET;
    logic [CNT_W-1:0]  cfg_cap    = CAP_RESET;

    t_reply replies_due[$];
    int     mismatches = 0;
    int     hold_left  = 0;
    bit     calm       = 1'b0;
    bit     pin_on     = 1'b0;
    t_reply pin_reply;
    t_step  steps [25];

    next_fit_block_allocator u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // Bound the run
    initial begin
        #2000000;
        $display("TEST FAILED");
        $finish;
    end

    task automatic note_mismatch(input string what, input int got, input int want);
        $display("mismatch at %0t: %s got %0d expected %0d", $time, what, got, want);
        mismatches++;
    endtask

    // Apply one request to the pool model and return the reply it earns
    function automatic t_reply predict_reply(input logic op, input logic [IDX_W-1:0] blk);
        t_reply r;
        int     cap;
        int     pos;
        int     n;
        bit     hit;
        cap = (int'(cfg_cap) == 0) ? 1 : (int'(cfg_cap) > BLOCKS) ? BLOCKS : int'(cfg_cap);
        r   = '{ST_FULL, '0, '0, '0};
        hit = 1'b0;
        if (op == OP_ALLOC) begin
            pos = (int'(scan_at) >= cap) ? 0 : int'(scan_at);
            if (int'(taken) < cap) begin
                for (n = 0; n < cap && !hit; n++) begin
                    if (!pool_marks[IDX_W'(pos)]) begin
                        hit                    = 1'b1;
                        pool_marks[IDX_W'(pos)] = 1'b1;
                        scan_at                = IDX_W'(pos);
                        taken                  = taken + CNT_W'(1);
                        r.status               = ST_OK;
                        r.blk                  = IDX_W'(pos);
                        r.offset               = OFF_W'(pos * (int'(cfg_bb) + 1) + 1);
                    end else begin
                        pos = (pos + 1 >= cap) ? 0 : pos + 1;
                    end
                end
            end
        end else if (int'(blk) >= cap || !pool_marks[blk]) begin
            r.status = ST_BAD_FREE;
        end else begin
            pool_marks[blk] = 1'b0;
            if (taken != '0) taken = taken - CNT_W'(1);
            r.status = ST_OK;
            r.blk    = blk;
            r.offset = OFF_W'(int'(blk) * (int'(cfg_bb) + 1) + 1);
        end
        r.used = taken;
        return r;
    endfunction

    // A block currently held in the model, or any index if none is
    function automatic logic [IDX_W-1:0] held_block();
        int held[$];
        for (int k = 0; k < BLOCKS; k++)
            if (pool_marks[IDX_W'(k)]) held.push_back(k);
        if (held.size() == 0) return IDX_W'($urandom_range(BLOCKS - 1));
        return IDX_W'(held[$urandom_range(held.size() - 1)]);
    endfunction

    // Track accepted requests, register writes and delivered replies
    always @(posedge i_clk) begin
        t_reply want;
        t_reply got;
        if (!i_rst_n) begin
            pool_marks = '0;
            scan_at    = '0;
            taken      = '0;
            cfg_bb     = BB_RESET;
            cfg_cap    = CAP_RESET;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                if (i_cfg_index == CFG_BLOCK_BYTES) cfg_bb = i_cfg_data;
                else cfg_cap = i_cfg_data[CNT_W-1:0];
            end
            if (s_axis_tvalid && s_axis_tready) begin
                want = predict_reply(s_axis_tuser, s_axis_tdata[IDX_W-1:0]);
                if (pin_on && want != pin_reply)
                    note_mismatch("pool model against table row", int'(want),
                                  int'(pin_reply));
                replies_due.push_back(want);
            end
            if (m_axis_tvalid && m_axis_tready) begin
                got.status = t_status'(m_axis_tuser);
                got.blk    = m_axis_tdata[IDX_W-1:0];
                got.offset = m_axis_tdata[IDX_W +: OFF_W];
                got.used   = m_axis_tdata[IDX_W + OFF_W +: CNT_W];
                if (replies_due.size() == 0) begin
                    note_mismatch("reply with no request due", int'(got), 0);
                end else begin
                    want = replies_due.pop_front();
                    if (got.status != want.status)
                        note_mismatch("status", int'(got.status), int'(want.status));
                    if (got.blk != want.blk)
                        note_mismatch("granted_index", int'(got.blk), int'(want.blk));
                    if (got.offset != want.offset)
                        note_mismatch("data_offset", int'(got.offset), int'(want.offset));
                    if (got.used != want.used)
                        note_mismatch("used_count", int'(got.used), int'(want.used));
                end
            end
        end
    end

    // Reply side: random stalls, or a counted hold-off when one is asked for
    initial begin
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_left > 0) begin
                m_axis_tready = 1'b0;
                hold_left--;
            end else begin
                m_axis_tready = calm || ($urandom_range(99) >= 36);
            end
        end
    end

    // Offer one request, with random idle cycles ahead of it
    task automatic push_request(input logic op, input logic [IDX_W-1:0] blk);
        while (!calm && $urandom_range(99) < 36) begin
            s_axis_tvalid = 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = {{IN_PAD_W{1'b0}}, blk};
        s_axis_tuser  = op;
        do @(posedge i_clk); while (!s_axis_tready);
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
    endtask

    // Hold until every reply is in, then let the pipeline settle
    task automatic wait_quiet();
        while (replies_due.size() != 0) @(negedge i_clk);
        repeat (6) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic sel, input logic [BB_W-1:0] value);
        wait_quiet();
        i_cfg_valid = 1'b1;
        i_cfg_index = sel;
        i_cfg_data  = value;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    initial begin
        int ph;
        int n;
        int roll;
        int alloc_pct;
        int guard;
        logic [BB_W-1:0] bb;
        logic [BB_W-1:0] cap;

        i_rst_n       = 1'b0;
        i_cfg_valid   = 1'b0;
        i_cfg_index   = CFG_BLOCK_BYTES;
        i_cfg_data    = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = OP_ALLOC;

        // Directed walk: kind, reg, value, op, index, pinned, expected reply
        steps = '{
            '{K_REQ, CFG_BLOCK_BYTES, 8'd0, OP_ALLOC, 6'd63, 1'b1, '{ST_OK, 6'd0, 14'd1, 7'd1}},
            '{K_REQ, CFG_BLOCK_BYTES, 8'd0, OP_ALLOC, 6'd0, 1'b1, '{ST_OK, 6'd1, 14'd3, 7'd2}},
            '{K_REQ, CFG_BLOCK_BYTES, 8'd0, OP_FREE, 6'd63, 1'b1,
              '{ST_BAD_FREE, 6'd0, 14'd0, 7'd2}},
            '{K_REQ, CFG_BLOCK_BYTES, 8'd0, OP_FREE, 6'd1, 1'b1, '{ST_OK, 6'd1, 14'd3, 7'd1}},
            '{K_REQ, CFG_BLOCK_BYTES, 8'd0, OP_ALLOC, 6'd42, 1'b1, '{ST_OK, 6'd1, 14'd3, 7'd2}},
            '{K_CFG, CFG_BLOCK_BYTES, 8'd0, OP_ALLOC, 6'd0, 1'b0, '{ST_OK, 6'd0, 14'd0, 7'd0}},
            // zero block size: offset is index plus one
            '{K_REQ, CFG_BLOCK_BYTES, 8'd0, OP_ALLOC, 6'd21, 1'b1, '{ST_OK, 6'd2, 14'd3, 7'd3}},
            '{K_CFG, CFG_BLOCK_BYTES, 8'd255, OP_ALLOC, 6'd0, 1'b0, '{ST_OK, 6'd0, 14'd0, 7'd0}},
            '{K_REQ, CFG_BLOCK_BYTES, 8'd0, OP_FREE, 6'd2, 1'b1, '{ST_OK, 6'd2, 14'd513, 7'd2}},
            '{K_CFG, CFG_BLOCKS_IN_USE, 8'd2, OP_ALLOC, 6'd0, 1'b0, '{ST_OK, 6'd0, 14'd0, 7'd0}},
            // pool full
            '{K_REQ, CFG_BLOCK_BYTES, 8'd0, OP_ALLOC, 6'd0, 1'b1, '{ST_FULL, 6'd0, 14'd0, 7'd2}},
            // free beyond the capacity
            '{K_REQ, CFG_BLOCK_BYTES, 8'd0, OP_FREE, 6'd2, 1'b1,
              '{ST_BAD_FREE, 6'd0, 14'd0, 7'd2}},
            '{K_REQ, CFG_BLOCK_BYTES, 8'd0, OP_FREE, 6'd0, 1'b1, '{ST_OK, 6'd0, 14'd1, 7'd1}},
            // capacity of zero acts as one
            '{K_CFG, CFG_BLOCKS_IN_USE, 8'd0, OP_ALLOC, 6'd0, 1'b0, '{ST_OK, 6'd0, 14'd0, 7'd0}},
            '{K_REQ, CFG_BLOCK_BYTES, 8'd0, OP_ALLOC, 6'd0, 1'b1, '{ST_FULL, 6'd0, 14'd0, 7'd1}},
            '{K_REQ, CFG_BLOCK_BYTES, 8'd0, OP_FREE, 6'd1, 1'b1,
              '{ST_BAD_FREE, 6'd0, 14'd0, 7'd1}},
            // capacity above the pool size acts as the pool size
            '{K_CFG, CFG_BLOCKS_IN_USE, 8'd127, OP_ALLOC, 6'd0, 1'b0,
              '{ST_OK, 6'd0, 14'd0, 7'd0}},
            '{K_REQ, CFG_BLOCK_BYTES, 8'd0, OP_FREE, 6'd1, 1'b1, '{ST_OK, 6'd1, 14'd257, 7'd0}},
            '{K_REQ, CFG_BLOCK_BYTES, 8'd0, OP_ALLOC, 6'd9, 1'b1, '{ST_OK, 6'd2, 14'd513, 7'd1}},
            // scan position beyond the capacity restarts at block zero
            '{K_CFG, CFG_BLOCKS_IN_USE, 8'd2, OP_ALLOC, 6'd0, 1'b0, '{ST_OK, 6'd0, 14'd0, 7'd0}},
            '{K_REQ, CFG_BLOCK_BYTES, 8'd0, OP_ALLOC, 6'd0, 1'b1, '{ST_OK, 6'd0, 14'd1, 7'd2}},
            '{K_REQ, CFG_BLOCK_BYTES, 8'd0, OP_ALLOC, 6'd0, 1'b1, '{ST_FULL, 6'd0, 14'd0, 7'd2}},
            '{K_CFG, CFG_BLOCKS_IN_USE, 8'd64, OP_ALLOC, 6'd0, 1'b0, '{ST_OK, 6'd0, 14'd0, 7'd0}},
            '{K_REQ, CFG_BLOCK_BYTES, 8'd0, OP_ALLOC, 6'd0, 1'b0, '{ST_OK, 6'd0, 14'd0, 7'd0}},
            '{K_REQ, CFG_BLOCK_BYTES, 8'd0, OP_FREE, 6'd0, 1'b0, '{ST_OK, 6'd0, 14'd0, 7'd0}}
        };

        repeat (4) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Walk the directed table
        foreach (steps[k]) begin
            if (steps[k].kind == K_CFG) begin
                write_reg(steps[k].sel, steps[k].value);
            end else begin
                pin_on    = steps[k].pinned;
                pin_reply = steps[k].want;
                push_request(steps[k].op, steps[k].blk);
            end
        end
        pin_on = 1'b0;

        // Random phases, each under its own register setting
        for (ph = 0; ph < 9; ph++) begin
            case (ph)
                0: begin bb = 8'd1;   cap = 8'd64;  end
                1: begin bb = 8'd0;   cap = 8'd6;   end
                2: begin bb = 8'd255; cap = 8'd64;  end
                3: begin bb = 8'd77;  cap = 8'd1;   end
                4: begin bb = 8'd128; cap = 8'd2;   end
                5: begin bb = 8'd3;   cap = 8'd100; end
                6: begin bb = 8'd255; cap = 8'd0;   end
                default: begin
                    bb  = BB_W'($urandom_range(255));
                    cap = BB_W'($urandom_range(1, BLOCKS));
                end
            endcase
            write_reg(CFG_BLOCK_BYTES, bb);
            write_reg(CFG_BLOCKS_IN_USE, cap);
            calm      = (ph == 2);
            alloc_pct = 50;
            for (n = 0; n < 67; n++) begin
                // swing between filling and draining the pool
                if (n % 16 == 0) begin
                    case ($urandom_range(2))
                        0: alloc_pct = 85;
                        1: alloc_pct = 50;
                        default: alloc_pct = 20;
                    endcase
                end
                // stall replies long enough to back up the request side
                if (ph == 4 && n == 5) hold_left = 200;
                // pause the requests until every reply is in
                if (ph == 6 && n == 30) wait_quiet();
                roll = $urandom_range(99);
                if (roll < alloc_pct)
                    push_request(OP_ALLOC, IDX_W'($urandom_range(BLOCKS - 1)));
                else if (roll < 92)
                    push_request(OP_FREE, held_block());
                else
                    push_request(OP_FREE, IDX_W'($urandom_range(BLOCKS - 1)));
            end
        end
        calm = 1'b0;

        // Drain and let any stray reply show up
        for (guard = 0; replies_due.size() != 0 && guard < 5000; guard++)
            @(negedge i_clk);
        repeat (10) @(negedge i_clk);
        if (replies_due.size() != 0)
            note_mismatch("replies never delivered", 0, replies_due.size());

        if (mismatches == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
